### rtl/pir_cfg_pkg.sv
// ----------------------------------------------------------------------------
// PIR sensor channel package
// Shared types, register map, phase codes and helpers for the sensor
// configuration sequencer and event clear handshake.
// ----------------------------------------------------------------------------
package pir_cfg_pkg;

    // Wait counter width and its largest value
    localparam int WAIT_WIDTH = 16;
    localparam logic [32:0] WAIT_MAX = (33'd1 << WAIT_WIDTH) - 33'd1;

    // Serial frame layout
    localparam int FRAME_BITS = 25;
    localparam logic [4:0] LAST_BIT = 5'(FRAME_BITS - 1);
    localparam logic [8:0] FIXED_TAIL = 9'h114;
    localparam logic [6:0] WIDTH_ONE  = 7'd95;
    localparam logic [6:0] WIDTH_ZERO = 7'd5;
    localparam logic [6:0] WIDTH_TERM = 7'd0;

    // Register map (index = paddr[4:2])
    localparam logic [2:0] REG_SENSITIVITY  = 3'd0;
    localparam logic [2:0] REG_BLIND_CODE   = 3'd1;
    localparam logic [2:0] REG_PULSE_COUNT  = 3'd2;
    localparam logic [2:0] REG_WINDOW_CODE  = 3'd3;
    localparam logic [2:0] REG_SETTLE_SLOTS = 3'd4;

    localparam logic [15:0] SETTLE_RESET = 16'd100;

    typedef enum logic [2:0] {
        PH_ARMED   = 3'd0,
        PH_PRE     = 3'd1,
        PH_SEND    = 3'd2,
        PH_POST    = 3'd3,
        PH_LOW     = 3'd4,
        PH_RELEASE = 3'd5
    } phase_t;

    typedef struct packed {
        logic [7:0]  sensitivity;
        logic [3:0]  blind_code;
        logic [1:0]  pulse_count;
        logic [1:0]  window_code;
        logic [15:0] settle_slots;
    } cfg_t;

    typedef struct packed {
        logic       busy_res;
        logic       motion;
        logic       drive_low;
        logic       pulse_valid;
        logic [6:0] pulse_width;
    } res_t;

    // Wait length: zero acts as one, saturate to what the counter holds
    function automatic logic [WAIT_WIDTH-1:0] settle_limit(input logic [15:0] slots);
        logic [32:0] s_ext;
        s_ext = 33'(slots);
        if (s_ext == 33'd0) begin
            s_ext = 33'd1;
        end
        if (s_ext > WAIT_MAX) begin
            s_ext = WAIT_MAX;
        end
        return WAIT_WIDTH'(s_ext);
    endfunction

    function automatic logic [FRAME_BITS-1:0] frame_word(input cfg_t cfg);
        return {cfg.sensitivity, cfg.blind_code, cfg.pulse_count, cfg.window_code,
                FIXED_TAIL};
    endfunction

endpackage

### rtl/pir_cfg_seq.sv
// ----------------------------------------------------------------------------
// PIR sensor channel sequencer
// Phase register, wait counter and bit pointer; computes one slot's result
// from the current state and the slot's inputs, advances on each step.
// ----------------------------------------------------------------------------
module pir_cfg_seq
    import pir_cfg_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic step_en,
    input  logic func,
    input  logic event_level,
    input  cfg_t cfg,
    output res_t res
);

    phase_t                phase_reg, phase_next;
    logic [WAIT_WIDTH-1:0] wait_reg, wait_next;
    logic [4:0]            bit_reg, bit_next;

    logic [WAIT_WIDTH-1:0] wait_inc;
    logic                  wait_done;
    logic [FRAME_BITS-1:0] frame;
    logic [4:0]            frame_pos;

    assign wait_inc  = wait_reg + WAIT_WIDTH'(1);
    assign wait_done = (wait_inc >= settle_limit(cfg.settle_slots));
    assign frame     = frame_word(cfg);
    assign frame_pos = LAST_BIT - bit_reg;

    always_comb begin
        phase_next      = phase_reg;
        wait_next       = wait_reg;
        bit_next        = bit_reg;
        res             = '0;
        res.busy_res    = 1'b1;
        case (phase_reg)
            PH_ARMED: begin
                res.busy_res = 1'b0;
                if (func) begin
                    phase_next = PH_PRE;
                    wait_next  = '0;
                    bit_next   = '0;
                end else if (event_level) begin
                    res.motion = 1'b1;
                    phase_next = PH_LOW;
                    wait_next  = '0;
                end
            end
            PH_PRE: begin
                wait_next = wait_done ? '0 : wait_inc;
                if (wait_done) begin
                    phase_next = PH_SEND;
                    bit_next   = '0;
                end
            end
            PH_SEND: begin
                res.pulse_valid = 1'b1;
                if (bit_reg <= LAST_BIT) begin
                    res.pulse_width = frame[frame_pos] ? WIDTH_ONE : WIDTH_ZERO;
                    bit_next        = bit_reg + 5'd1;
                end else begin
                    res.pulse_width = WIDTH_TERM;
                    bit_next        = '0;
                    phase_next      = PH_POST;
                    wait_next       = '0;
                end
            end
            PH_POST: begin
                wait_next = wait_done ? '0 : wait_inc;
                if (wait_done) begin
                    phase_next = PH_ARMED;
                end
            end
            PH_LOW: begin
                res.drive_low = 1'b1;
                wait_next     = wait_done ? '0 : wait_inc;
                if (wait_done) begin
                    phase_next = PH_RELEASE;
                end
            end
            PH_RELEASE: begin
                wait_next = wait_done ? '0 : wait_inc;
                if (wait_done) begin
                    phase_next = PH_ARMED;
                end
            end
            default: begin
                phase_next = PH_ARMED;
                wait_next  = '0;
                bit_next   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_ARMED;
            wait_reg  <= '0;
            bit_reg   <= '0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            wait_reg  <= wait_next;
            bit_reg   <= bit_next;
        end
    end

endmodule

### rtl/pir_sensor_config_and_event_clear.sv
// ----------------------------------------------------------------------------
// PIR sensor configuration and event clear
// One sensor channel: serial configuration frame sequencer plus the motion
// event clear handshake, one time slot per input beat.
// ----------------------------------------------------------------------------
//
//   Channel   | Direction | Beat contents
//   ----------+-----------+------------------------------------------------
//   s_axis    | in        | one time slot: event level, start request
//   m_axis    | out       | one result per slot: pulse, drive, motion, busy
//   APB       | in/out    | sensitivity, blind time, pulse count, window,
//             |           | settle slots
//
// One slot enters per clock while s_tready is high; its result lands in the
// output register on the same edge and is offered on m_axis in the cycle
// after. The sequencer state advances only on an accepted input beat.
// A stalled output register holds its beat; s_tready drops only while that
// beat waits and m_tready is low, so a new slot is taken in the cycle the
// old result leaves.
// Reset (aresetn, synchronous): phase armed, counters zero, output empty,
// registers to zero with settle slots at 100.
module pir_sensor_config_and_event_clear
    import pir_cfg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [0] event_level, [7:1] zero
    input  logic        s_tuser,    // [0] func (start request)

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [6:0] pulse_width, [7] pulse_valid,
                                    // [8] drive_low, [9] motion, [10] busy_res

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t  cfg_reg;
    res_t  res;
    logic  s_fire;
    logic  cfg_wr;
    logic  [2:0] reg_idx;
    logic  m_tvalid_reg;
    res_t  m_data_reg;

    // Accept a slot whenever the output register is empty or draining
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    // Configuration port
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sensitivity  <= '0;
            cfg_reg.blind_code   <= '0;
            cfg_reg.pulse_count  <= '0;
            cfg_reg.window_code  <= '0;
            cfg_reg.settle_slots <= SETTLE_RESET;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_SENSITIVITY:  cfg_reg.sensitivity  <= pwdata[7:0];
                REG_BLIND_CODE:   cfg_reg.blind_code   <= pwdata[3:0];
                REG_PULSE_COUNT:  cfg_reg.pulse_count  <= pwdata[1:0];
                REG_WINDOW_CODE:  cfg_reg.window_code  <= pwdata[1:0];
                REG_SETTLE_SLOTS: cfg_reg.settle_slots <= pwdata[15:0];
                default: ;  // drop writes outside the map
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SENSITIVITY:  prdata = 32'(cfg_reg.sensitivity);
            REG_BLIND_CODE:   prdata = 32'(cfg_reg.blind_code);
            REG_PULSE_COUNT:  prdata = 32'(cfg_reg.pulse_count);
            REG_WINDOW_CODE:  prdata = 32'(cfg_reg.window_code);
            REG_SETTLE_SLOTS: prdata = 32'(cfg_reg.settle_slots);
            default:          prdata = '0;
        endcase
    end

    // Slot sequencer: result for the current beat, state advances on accept
    pir_cfg_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (s_fire),
        .func        (s_tuser),
        .event_level (s_tdata[0]),
        .cfg         (cfg_reg),
        .res         (res)
    );

    // Output register: load on accept, hold while stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_fire) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_data_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = 16'(m_data_reg);

endmodule

### rtl/pir_cfg_chk.sv
// ----------------------------------------------------------------------------
// PIR sensor channel port checker
// Port-level checks on the result stream and the input backpressure.
// ----------------------------------------------------------------------------
module pir_cfg_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // No backpressure without a waiting result
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // Every accepted slot yields a result on the next cycle
    a_slot_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted slot produced no result");

    // Pulse width only in a pulse slot, and only one of the three codes
    a_width_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7] || m_tdata[6:0] == 7'd0) &&
                     (m_tdata[6:0] == 7'd0 || m_tdata[6:0] == 7'd5 ||
                      m_tdata[6:0] == 7'd95))
        else $error("bad pulse width");

    // Motion reported only from the armed phase, with no pulse or drive
    a_motion_armed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[9] |-> !m_tdata[10] && !m_tdata[8] && !m_tdata[7])
        else $error("motion outside armed phase");

endmodule

bind pir_sensor_config_and_event_clear pir_cfg_chk u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
